// ----- hdl/ilt_pkg.sv -----
// Package for the INI line tokenizer: result kinds, character codes,
// counter widths and the result record used by the tokenizer and its channels.
// No dependencies.
package ilt_pkg;

	// Width of every numeric result field and of the line counter.
	localparam int FIELD_W = 20;

	// Default width of the byte offset and length counters.
	localparam int POSITION_BITS_DEF = 20;

	// Result queue depth; a power of two.
	localparam int FIFO_DEPTH = 4;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_SECTION = 3'd0,
		KIND_KEY     = 3'd1,
		KIND_VALUE   = 3'd2,
		KIND_ERROR   = 3'd3,
		KIND_END     = 3'd4
	} token_kind_t;

	// Character codes that steer the parse.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	// One result item as it sits in the result queue.
	typedef struct packed {
		token_kind_t          kind;
		logic [FIELD_W-1:0]   start;
		logic [FIELD_W-1:0]   length;
		logic [FIELD_W-1:0]   line;
		logic                 run_last;
	} token_t;

	// Printable ASCII or any byte above DEL.
	function automatic logic is_text(input logic [7:0] c);
		return (c >= CH_SPACE && c < CH_DEL) || c > CH_DEL;
	endfunction

	// Tab or space.
	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_TAB || c == CH_SPACE;
	endfunction

endpackage

// ----- hdl/ilt_text_if.sv -----
// Input channel of the INI line tokenizer: one text byte per item.
// Depends on nothing.
interface ilt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- hdl/ilt_token_if.sv -----
// Output channel of the INI line tokenizer: one token per item.
// Depends on ilt_pkg for the kind type and field width.
interface ilt_token_if
	import ilt_pkg::*;
;
	logic                valid;
	logic                ready;
	token_kind_t         token_kind;
	logic [FIELD_W-1:0]  token_start;
	logic [FIELD_W-1:0]  token_length;
	logic [FIELD_W-1:0]  line_number;
	logic                run_last;

	modport source (output valid, output token_kind, output token_start, output token_length,
		output line_number, output run_last, input ready);
	modport sink (input valid, input token_kind, input token_start, input token_length,
		input line_number, input run_last, output ready);
endinterface

// ----- hdl/ini_line_tokenizer.sv -----
// Channel  | Dir | Payload                                              | Handshake
// text     | in  | text_byte, end_of_text                              | valid/ready
// token    | out | token_kind, token_start, token_length, line_number, | valid/ready
//          |     | run_last                                             |
//
// One byte is taken into an input register, decoded against the parse state and
// its zero, one or two tokens are written into a four-entry queue. A byte enters
// every cycle while the queue holds at most two tokens; the token side drains one
// item per cycle while token.ready is high, so bytes that yield two tokens set the
// pace. Reset (arst_n low) returns to line start with all counters at zero.
// A stalled token side lets three or more tokens queue, then holds text.ready low.
//
// Depends on ilt_pkg, ilt_text_if and ilt_token_if.
module ini_line_tokenizer
	import ilt_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ilt_text_if.sink     text,
	ilt_token_if.source  token
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		M_LSTART  = 4'd0,
		M_LEAD    = 4'd1,
		M_SKIP    = 4'd2,
		M_SECLEAD = 4'd3,
		M_SEC     = 4'd4,
		M_KEY     = 4'd5,
		M_KEYSP   = 4'd6,
		M_VLEAD   = 4'd7,
		M_VAL     = 4'd8,
		M_ERR     = 4'd9
	} mode_t;

	typedef enum logic [1:0] {
		H_NONE = 2'd0,
		H_SEC  = 2'd1,
		H_KEY  = 2'd2,
		H_VAL  = 2'd3
	} handler_t;

	// Low field bits of a position-wide counter, zero extended when narrower.
	function automatic logic [FIELD_W-1:0] to_field(input logic [POSITION_BITS-1:0] v);
		logic [POSITION_BITS+FIELD_W-1:0] ext;
		ext = {{FIELD_W{1'b0}}, v};
		return ext[FIELD_W-1:0];
	endfunction

	function automatic logic [POSITION_BITS-1:0] sat_pos(input logic [POSITION_BITS-1:0] v);
		return (&v) ? v : v + POSITION_BITS'(1);
	endfunction

	// Input register.
	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      last_s1;

	// Parse state.
	mode_t                     mode_q;
	logic [POSITION_BITS-1:0]  pos_q;
	logic [FIELD_W-1:0]        line_q;
	logic [POSITION_BITS-1:0]  mark_q;
	logic [POSITION_BITS-1:0]  raw_q;
	logic [POSITION_BITS-1:0]  trim_q;

	// Result queue.
	token_t                    fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]          head_q;
	logic [PTR_W-1:0]          tail_q;
	logic [CNT_W-1:0]          count_q;

	logic                      advance;
	logic                      pop;
	logic [1:0]                push_n;
	token_t                    res0;
	token_t                    res1;

	mode_t                     mode_n;
	logic [POSITION_BITS-1:0]  pos_n;
	logic [FIELD_W-1:0]        line_n;
	logic [POSITION_BITS-1:0]  mark_n;
	logic [POSITION_BITS-1:0]  raw_n;
	logic [POSITION_BITS-1:0]  trim_n;

	// Handshake on both sides.
	assign advance    = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign text.ready = !valid_s1 || advance;
	assign pop        = token.valid && token.ready;

	// Byte decode: mode transition, counter updates and the tokens of this byte.
	always_comb begin
		logic [7:0]      c;
		logic            fnb;
		handler_t        hsel;
		logic            tk_v;
		token_t          tk;
		logic            cl_v;
		token_t          cl;
		logic            end_v;
		token_t          endtok;
		logic            do_err;
		logic [POSITION_BITS-1:0] raw_inc;

		c      = byte_s1;
		fnb    = 1'b0;
		hsel   = H_NONE;
		tk_v   = 1'b0;
		tk     = '0;
		cl_v   = 1'b0;
		cl     = '0;
		end_v  = 1'b0;
		endtok = '0;
		do_err = 1'b0;
		mode_n = mode_q;
		pos_n  = sat_pos(pos_q);
		line_n = line_q;
		mark_n = mark_q;
		raw_n  = raw_q;
		trim_n = trim_q;

		// Line level transitions.
		case (mode_q)
			M_LSTART: begin
				line_n = (&line_q) ? line_q : line_q + FIELD_W'(1);
				if (c == CH_NL) begin
					mode_n = M_LSTART;
				end else if (c == CH_CR) begin
					mode_n = M_SKIP;
				end else if (is_blank(c)) begin
					mode_n = M_LEAD;
				end else begin
					fnb = 1'b1;
				end
			end
			M_LEAD: begin
				if (c == CH_NL) begin
					mode_n = M_LSTART;
				end else if (!is_blank(c)) begin
					fnb = 1'b1;
				end
			end
			M_SKIP: begin
				if (c == CH_NL) begin
					mode_n = M_LSTART;
				end
			end
			M_SECLEAD: begin
				if (c != CH_SPACE) begin
					mark_n = pos_q;
					raw_n  = '0;
					trim_n = '0;
					hsel   = H_SEC;
				end
			end
			M_SEC: hsel = H_SEC;
			M_KEY: hsel = H_KEY;
			M_KEYSP: begin
				if (c == CH_EQUAL) begin
					hsel = H_KEY;
				end else if (!is_blank(c)) begin
					do_err = 1'b1;
				end
			end
			M_VLEAD: begin
				if (c == CH_NL) begin
					mode_n = M_LSTART;
				end else if (!is_blank(c)) begin
					mark_n = pos_q;
					raw_n  = '0;
					trim_n = '0;
					hsel   = H_VAL;
				end
			end
			M_VAL: hsel = H_VAL;
			default: mode_n = M_ERR;
		endcase

		// First non-blank byte of a line picks comment, section or key.
		if (fnb) begin
			if (c == CH_HASH || c == CH_SEMI) begin
				mode_n = M_SKIP;
			end else if (c == CH_LBRACK) begin
				mode_n = M_SECLEAD;
			end else begin
				mark_n = pos_q;
				raw_n  = '0;
				trim_n = '0;
				hsel   = H_KEY;
			end
		end

		// Token body handlers.
		raw_inc = sat_pos(raw_n);
		case (hsel)
			H_SEC: begin
				mode_n = M_SEC;
				if (c == CH_RBRACK) begin
					tk_v   = 1'b1;
					tk     = '{KIND_SECTION, to_field(mark_n), to_field(trim_n), line_n, 1'b0};
					mode_n = M_SKIP;
				end else if (is_text(c)) begin
					raw_n = raw_inc;
					if (!is_blank(c)) begin
						trim_n = raw_inc;
					end
				end else begin
					do_err = 1'b1;
				end
			end
			H_KEY: begin
				mode_n = M_KEY;
				if (c == CH_EQUAL) begin
					tk_v   = 1'b1;
					tk     = '{KIND_KEY, to_field(mark_n), to_field(raw_n), line_n, 1'b0};
					mode_n = M_VLEAD;
				end else if (is_blank(c)) begin
					mode_n = M_KEYSP;
				end else if (is_text(c)) begin
					raw_n = raw_inc;
				end else begin
					do_err = 1'b1;
				end
			end
			H_VAL: begin
				mode_n = M_VAL;
				if (c == CH_NL) begin
					tk_v   = 1'b1;
					tk     = '{KIND_VALUE, to_field(mark_n), to_field(trim_n), line_n, 1'b0};
					mode_n = M_LSTART;
				end else if (c == CH_TAB || is_text(c)) begin
					raw_n = raw_inc;
					if (!is_blank(c)) begin
						trim_n = raw_inc;
					end
				end else begin
					do_err = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Parse error at this byte.
		if (do_err) begin
			tk_v   = 1'b1;
			tk     = '{KIND_ERROR, to_field(pos_q), '0, line_n, 1'b0};
			mode_n = M_ERR;
		end

		// End of text closes the open line and, unless the parse is in error, reports the line count.
		if (last_s1) begin
			if (mode_n inside {M_SECLEAD, M_SEC, M_KEY, M_KEYSP}) begin
				cl_v   = 1'b1;
				cl     = '{KIND_ERROR, to_field(pos_q), '0, line_n, 1'b0};
				mode_n = M_ERR;
			end else if (mode_n == M_VAL) begin
				cl_v = 1'b1;
				cl   = '{KIND_VALUE, to_field(mark_n), to_field(trim_n), line_n, 1'b0};
			end
			if (mode_n != M_ERR) begin
				end_v  = 1'b1;
				endtok = '{KIND_END, '0, '0, line_n, 1'b0};
			end
			mode_n = M_LSTART;
			pos_n  = '0;
			line_n = '0;
			mark_n = '0;
			raw_n  = '0;
			trim_n = '0;
		end

		// Order the tokens of this byte; at most two are ever present.
		push_n = 2'(tk_v) + 2'(cl_v) + 2'(end_v);
		res0   = tk_v ? tk : (cl_v ? cl : endtok);
		res1   = endtok;
		res0.run_last = (push_n == 2'd1);
		res1.run_last = 1'b1;
	end

	// Input register and parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_LSTART;
			pos_q    <= '0;
			line_q   <= '0;
			mark_q   <= '0;
			raw_q    <= '0;
			trim_q   <= '0;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (advance) begin
				mode_q <= mode_n;
				pos_q  <= pos_n;
				line_q <= line_n;
				mark_q <= mark_n;
				raw_q  <= raw_n;
				trim_q <= trim_n;
			end
		end
	end

	// Input payload register.
	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.end_of_text;
		end
	end

	// Result queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + PTR_W'(1);
			end
			if (advance) begin
				tail_q <= tail_q + PTR_W'(push_n);
			end
			count_q <= count_q + (advance ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (advance && push_n != 2'd0) begin
			fifo_q[tail_q] <= res0;
		end
		if (advance && push_n == 2'd2) begin
			fifo_q[tail_q + PTR_W'(1)] <= res1;
		end
	end

	// Token channel.
	assign token.valid        = (count_q != '0);
	assign token.token_kind   = fifo_q[head_q].kind;
	assign token.token_start  = fifo_q[head_q].start;
	assign token.token_length = fifo_q[head_q].length;
	assign token.line_number  = fifo_q[head_q].line;
	assign token.run_last     = fifo_q[head_q].run_last;

	// The queue never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	// Two tokens from one byte happen only at the end of the text.
	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && push_n == 2'd2 |-> last_s1)
		else $error("two tokens from a byte that does not end the text");

	// After an error, bytes before the end of the text yield nothing.
	a_silent_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_q == M_ERR |-> push_n == 2'd0)
		else $error("token produced after a parse error");

	// The end of the text returns the parser to line start at offset zero.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> mode_q == M_LSTART && pos_q == '0 && line_q == '0)
		else $error("parser not restarted after end of text");

	// Within a text the byte offset never goes down.
	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 |=> pos_q >= $past(pos_q))
		else $error("byte offset went backwards");

endmodule
